// ===== rtl/ccrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ccrt_pkg: shared types, constants and helpers for the cube corner core
// Coordinate widths, request codes, reciprocal table for the series terms
// and saturation / reset helpers used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package ccrt_pkg;

	localparam int COORD_BITS = 32;
	localparam int ANGLE_BITS = 16;
	localparam int EDGE_BITS  = 15;
	localparam int OFS_BITS   = 36;
	localparam int ACC_BITS   = 37;
	localparam int OPA_BITS   = 35;
	localparam int OPB_BITS   = 32;
	localparam int PROD_BITS  = OPA_BITS + OPB_BITS;
	localparam int TRIG_BITS  = 18;

	// Request codes.
	localparam logic [1:0] REQ_ROTATE = 2'd0;
	localparam logic [1:0] REQ_MOVE   = 2'd1;
	localparam logic [1:0] REQ_PLACE  = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;
	localparam logic [1:0] REG_EDGE     = 2'd3;

	// pi/2 in Q2.30.
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'd1073741824;

	localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
	localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} corner_t;

	// Reciprocal of the series denominator for term it (sine or cosine),
	// scaled so that (v * recip) >> shift equals v / den for v below 2^31.
	function automatic logic [31:0] series_recip(input logic is_cos, input logic [2:0] it);
		logic [31:0] r;
		r = 32'd0;
		if (!is_cos) begin
			unique case (it)
				3'd0: r = 32'd2498890064;
				3'd1: r = 32'd3817748708;
				3'd2: r = 32'd3272356036;
				3'd3: r = 32'd3435973837;
				default: r = 32'd2863311531;
			endcase
		end else begin
			unique case (it)
				3'd0: r = 32'd3054198967;
				3'd1: r = 32'd2454267027;
				3'd2: r = 32'd2290649225;
				3'd3: r = 32'd2863311531;
				default: r = 32'd2147483648;
			endcase
		end
		return r;
	endfunction

	// Quotient taken from the scaled product for term it.
	function automatic logic [30:0] series_quot(input logic is_cos, input logic [2:0] it,
		input logic [PROD_BITS-1:0] p);
		logic [30:0] q;
		q = 31'd0;
		if (!is_cos) begin
			unique case (it)
				3'd0, 3'd1: q = 31'(p[38 +: 29]);
				3'd2:       q = 31'(p[37 +: 30]);
				3'd3:       q = p[36 +: 31];
				default:    q = p[34 +: 31];
			endcase
		end else begin
			unique case (it)
				3'd0:    q = 31'(p[38 +: 29]);
				3'd1:    q = 31'(p[37 +: 30]);
				3'd2:    q = p[36 +: 31];
				3'd3:    q = p[35 +: 31];
				default: q = p[32 +: 31];
			endcase
		end
		return q;
	endfunction

	// Clamp a wide signed value to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [36:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[COORD_BITS-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [36:0] ext_coord(input logic signed [COORD_BITS-1:0] v);
		return {{(37-COORD_BITS){v[COORD_BITS-1]}}, v};
	endfunction

	// Reset cube: edge 50 about the origin.
	function automatic corner_t corner_init(input logic [2:0] k);
		corner_t c;
		c.x = k[0] ? -32'sd1638400 : 32'sd1638400;
		c.y = k[1] ? -32'sd1638400 : 32'sd1638400;
		c.z = k[2] ? -32'sd1638400 : 32'sd1638400;
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cube_corner_rotate_translate_core.sv =====
// Rotate: 69 trig and 96 rotation products, each in an operand, a multiply and a
// write-back step through the one shared multiplier, plus a load and a store step per
// corner; move and place one step per corner. Then eight results, one per cycle while
// out_stall is low; one request at a time, in_stall until the eighth result leaves.
// Reset: asynchronous, clears control, sets registers to their defaults and the
// cube to edge 50 about the origin.
// ----------------------------------------------------------------------------
// cube_corner_rotate_translate_core
// Keeps a cube's center and corners and rotates, moves or places it, using
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_corner_rotate_translate_core import ccrt_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [3:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// Request channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic [ANGLE_BITS-1:0]         angle_x,
	input  wire logic [ANGLE_BITS-1:0]         angle_y,
	input  wire logic [ANGLE_BITS-1:0]         angle_z,
	input  wire logic signed [COORD_BITS-1:0]  shift_x,
	input  wire logic signed [COORD_BITS-1:0]  shift_y,
	input  wire logic signed [COORD_BITS-1:0]  shift_z,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [2:0]                         corner_index,
	output logic signed [COORD_BITS-1:0]       corner_x,
	output logic signed [COORD_BITS-1:0]       corner_y,
	output logic signed [COORD_BITS-1:0]       corner_z,
	output logic                               last_corner
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TRIG  = 3'd1;
	localparam logic [2:0] S_ROT   = 3'd2;
	localparam logic [2:0] S_MOVE  = 3'd3;
	localparam logic [2:0] S_PLACE = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	localparam logic [2:0] TS_X    = 3'd0;
	localparam logic [2:0] TS_X2   = 3'd1;
	localparam logic [2:0] TS_SL   = 3'd2;
	localparam logic [2:0] TS_SF   = 3'd3;
	localparam logic [2:0] TS_CL   = 3'd4;

	localparam logic [1:0] R_LOAD  = 2'd0;
	localparam logic [1:0] R_TURN  = 2'd1;
	localparam logic [1:0] R_STORE = 2'd2;

	localparam logic [1:0] PH_OPS  = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_WB   = 2'd2;

	logic [2:0] state_q;
	logic [2:0] ts_q;
	logic [1:0] rs_q;
	logic [1:0] ph_q;
	logic [1:0] ai_q;
	logic [1:0] tn_q;
	logic [1:0] pi_q;
	logic [2:0] it_q;
	logic       hb_q;
	logic [2:0] cidx_q;

	logic [ANGLE_BITS-1:0]        ang_x_q, ang_y_q, ang_z_q;
	logic signed [COORD_BITS-1:0] sh_x_q, sh_y_q, sh_z_q;

	logic signed [COORD_BITS-1:0] scx_q, scy_q, scz_q;
	logic [EDGE_BITS-1:0]         edge_q;

	logic signed [COORD_BITS-1:0] cen_x_q, cen_y_q, cen_z_q;
	corner_t                      corner_q [8];

	logic [29:0] xa_q, x2_q, v_q;
	logic [30:0] t_q, sv_q;
	logic signed [TRIG_BITS-1:0] sin_x_q, cos_x_q, sin_y_q, cos_y_q, sin_z_q, cos_z_q;

	logic signed [OFS_BITS-1:0] d0_q, d1_q, d2_q;
	logic signed [ACC_BITS-1:0] acca_q, accb_q;

	logic [OPA_BITS-1:0]  opa_q;
	logic [OPB_BITS-1:0]  opb_q;
	logic                 neg_q;
	logic [PROD_BITS-1:0] prod_q;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Configuration read-back.
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			REG_CENTER_X: prdata = scx_q;
			REG_CENTER_Y: prdata = scy_q;
			REG_CENTER_Z: prdata = scz_q;
			default:      prdata = {{(32-EDGE_BITS){1'b0}}, edge_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scx_q  <= '0;
			scy_q  <= '0;
			scz_q  <= '0;
			edge_q <= 15'd50;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_CENTER_X: scx_q  <= pwdata;
				REG_CENTER_Y: scy_q  <= pwdata;
				REG_CENTER_Z: scz_q  <= pwdata;
				default:      edge_q <= pwdata[EDGE_BITS-1:0];
			endcase
		end
	end

	// Angle fold for the trig step in progress.
	logic [ANGLE_BITS-1:0] ang;
	logic [1:0]            quad;
	logic [13:0]           arem;
	logic                  swap;
	logic [14:0]           mfold;
	always_comb begin
		unique case (ai_q)
			2'd0:    ang = ang_x_q;
			2'd1:    ang = ang_y_q;
			default: ang = ang_z_q;
		endcase
		quad  = ang[15:14];
		arem  = ang[13:0];
		swap  = arem > 14'd8192;
		mfold = swap ? (15'd16384 - {1'b0, arem}) : {1'b0, arem};
	end

	// Series term update and final rounding of sine and cosine.
	logic [30:0]                 quot, tnew;
	logic [30:0]                 sr_sum, cr_sum;
	logic signed [TRIG_BITS-1:0] sr, cr, sa, ca, s_fin, c_fin;
	always_comb begin
		quot   = series_quot(ts_q == TS_CL, it_q, prod_q);
		tnew   = Q30_ONE - quot;
		sr_sum = sv_q + 31'd8192;
		cr_sum = tnew + 31'd8192;
		sr     = {1'b0, sr_sum[30:14]};
		cr     = {1'b0, cr_sum[30:14]};
		sa     = swap ? cr : sr;
		ca     = swap ? sr : cr;
		unique case (quad)
			2'd0: begin s_fin = sa;  c_fin = ca;  end
			2'd1: begin s_fin = ca;  c_fin = -sa; end
			2'd2: begin s_fin = -sa; c_fin = -ca; end
			default: begin s_fin = -ca; c_fin = sa; end
		endcase
	end

	// Rotation operands for the current turn and product.
	logic signed [OFS_BITS-1:0]  rot_a, rot_b, rot_d;
	logic signed [TRIG_BITS-1:0] rot_s, rot_c, rot_t;
	logic [OFS_BITS-1:0]         d_mag;
	logic [TRIG_BITS-1:0]        t_mag;
	always_comb begin
		unique case (tn_q)
			2'd0: begin rot_a = d1_q; rot_b = d2_q; rot_s = sin_x_q; rot_c = cos_x_q; end
			2'd1: begin rot_a = d2_q; rot_b = d0_q; rot_s = sin_y_q; rot_c = cos_y_q; end
			default: begin rot_a = d0_q; rot_b = d1_q; rot_s = sin_z_q; rot_c = cos_z_q; end
		endcase
		unique case (pi_q)
			2'd0: begin rot_d = rot_a; rot_t = rot_c; end
			2'd1: begin rot_d = rot_b; rot_t = rot_s; end
			2'd2: begin rot_d = rot_a; rot_t = rot_s; end
			default: begin rot_d = rot_b; rot_t = rot_c; end
		endcase
		d_mag = rot_d[OFS_BITS-1] ? -rot_d : rot_d;
		t_mag = rot_t[TRIG_BITS-1] ? -rot_t : rot_t;
	end

	// Rounded signed product, half away from zero.
	logic [PROD_BITS-1:0]       rnd_sum;
	logic signed [ACC_BITS-1:0] rprod, accb_sum;
	always_comb begin
		rnd_sum  = prod_q + PROD_BITS'(32768);
		rprod    = {1'b0, rnd_sum[16 +: ACC_BITS-1]};
		rprod    = neg_q ? -rprod : rprod;
		accb_sum = accb_q + rprod;
	end

	// Current corner and the half edge for load, move and place.
	corner_t                   cur;
	logic [EDGE_BITS+14:0]     half_edge;
	logic signed [36:0]        hv;
	assign cur       = corner_q[cidx_q];
	assign half_edge = {edge_q, 15'd0};
	assign hv        = {7'd0, half_edge};

	// Shared multiplier and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ts_q    <= TS_X;
			rs_q    <= R_LOAD;
			ph_q    <= PH_OPS;
			ai_q    <= '0;
			tn_q    <= '0;
			pi_q    <= '0;
			it_q    <= '0;
			hb_q    <= 1'b0;
			cidx_q  <= '0;
			cen_x_q <= '0;
			cen_y_q <= '0;
			cen_z_q <= '0;
			for (int k = 0; k < 8; k++) begin
				corner_q[k] <= corner_init(3'(k));
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ang_x_q <= angle_x;
						ang_y_q <= angle_y;
						ang_z_q <= angle_z;
						sh_x_q  <= shift_x;
						sh_y_q  <= shift_y;
						sh_z_q  <= shift_z;
						cidx_q  <= '0;
						ai_q    <= '0;
						ts_q    <= TS_X;
						ph_q    <= PH_OPS;
						priority case (req_type)
							REQ_ROTATE: state_q <= S_TRIG;
							REQ_MOVE:   state_q <= S_MOVE;
							REQ_PLACE:  state_q <= S_PLACE;
							default:    state_q <= S_OUT;
						endcase
					end
				end

				S_TRIG: begin
					unique case (ph_q)
						PH_OPS: begin
							neg_q <= 1'b0;
							priority case (ts_q)
								TS_X: begin
									opa_q <= OPA_BITS'(mfold);
									opb_q <= HALF_PI_Q30;
								end
								TS_X2: begin
									opa_q <= OPA_BITS'(xa_q);
									opb_q <= OPB_BITS'(xa_q);
								end
								TS_SF: begin
									opa_q <= OPA_BITS'(xa_q);
									opb_q <= OPB_BITS'(t_q);
								end
								default: begin
									if (!hb_q) begin
										opa_q <= OPA_BITS'(x2_q);
										opb_q <= OPB_BITS'(t_q);
									end else begin
										opa_q <= OPA_BITS'(v_q);
										opb_q <= series_recip(ts_q == TS_CL, it_q);
									end
								end
							endcase
							ph_q <= PH_MUL;
						end
						PH_MUL: begin
							prod_q <= opa_q * opb_q;
							ph_q   <= PH_WB;
						end
						default: begin
							ph_q <= PH_OPS;
							priority case (ts_q)
								TS_X: begin
									xa_q <= 30'((prod_q + PROD_BITS'(8192)) >> 14);
									ts_q <= TS_X2;
								end
								TS_X2: begin
									x2_q <= prod_q[30 +: 30];
									t_q  <= Q30_ONE;
									it_q <= '0;
									hb_q <= 1'b0;
									ts_q <= TS_SL;
								end
								TS_SF: begin
									sv_q <= prod_q[30 +: 31];
									t_q  <= Q30_ONE;
									it_q <= '0;
									hb_q <= 1'b0;
									ts_q <= TS_CL;
								end
								default: begin
									if (!hb_q) begin
										v_q  <= prod_q[30 +: 30];
										hb_q <= 1'b1;
									end else begin
										t_q  <= tnew;
										hb_q <= 1'b0;
										if (it_q != 3'd4) begin
											it_q <= it_q + 3'd1;
										end else if (ts_q == TS_SL) begin
											ts_q <= TS_SF;
										end else begin
											// Cosine done: sine and cosine of this axis are final.
											unique case (ai_q)
												2'd0: begin sin_x_q <= s_fin; cos_x_q <= c_fin; end
												2'd1: begin sin_y_q <= s_fin; cos_y_q <= c_fin; end
												default: begin
													sin_z_q <= s_fin;
													cos_z_q <= c_fin;
												end
											endcase
											ts_q <= TS_X;
											if (ai_q == 2'd2) begin
												state_q <= S_ROT;
												rs_q    <= R_LOAD;
												cidx_q  <= '0;
											end else begin
												ai_q <= ai_q + 2'd1;
											end
										end
									end
								end
							endcase
						end
					endcase
				end

				S_ROT: begin
					priority case (rs_q)
						R_LOAD: begin
							d0_q <= OFS_BITS'(ext_coord(cur.x) - ext_coord(cen_x_q));
							d1_q <= OFS_BITS'(ext_coord(cur.y) - ext_coord(cen_y_q));
							d2_q <= OFS_BITS'(ext_coord(cur.z) - ext_coord(cen_z_q));
							tn_q <= '0;
							pi_q <= '0;
							ph_q <= PH_OPS;
							rs_q <= R_TURN;
						end
						R_TURN: begin
							unique case (ph_q)
								PH_OPS: begin
									opa_q <= d_mag[OPA_BITS-1:0];
									opb_q <= OPB_BITS'(t_mag);
									neg_q <= rot_d[OFS_BITS-1] ^ rot_t[TRIG_BITS-1];
									ph_q  <= PH_MUL;
								end
								PH_MUL: begin
									prod_q <= opa_q * opb_q;
									ph_q   <= PH_WB;
								end
								default: begin
									ph_q <= PH_OPS;
									pi_q <= pi_q + 2'd1;
									unique case (pi_q)
										2'd0: acca_q <= rprod;
										2'd1: acca_q <= acca_q - rprod;
										2'd2: accb_q <= rprod;
										default: begin
											// Both products of the pair are in: write the turned pair.
											unique case (tn_q)
												2'd0: begin
													d1_q <= acca_q[OFS_BITS-1:0];
													d2_q <= accb_sum[OFS_BITS-1:0];
												end
												2'd1: begin
													d2_q <= acca_q[OFS_BITS-1:0];
													d0_q <= accb_sum[OFS_BITS-1:0];
												end
												default: begin
													d0_q <= acca_q[OFS_BITS-1:0];
													d1_q <= accb_sum[OFS_BITS-1:0];
												end
											endcase
											if (tn_q == 2'd2) begin
												rs_q <= R_STORE;
											end else begin
												tn_q <= tn_q + 2'd1;
											end
										end
									endcase
								end
							endcase
						end
						default: begin
							corner_q[cidx_q].x <= sat_coord(ext_coord(cen_x_q) + 37'(d0_q));
							corner_q[cidx_q].y <= sat_coord(ext_coord(cen_y_q) + 37'(d1_q));
							corner_q[cidx_q].z <= sat_coord(ext_coord(cen_z_q) + 37'(d2_q));
							rs_q   <= R_LOAD;
							cidx_q <= cidx_q + 3'd1;
							if (cidx_q == 3'd7) begin
								state_q <= S_OUT;
							end
						end
					endcase
				end

				S_MOVE: begin
					if (cidx_q == 3'd0) begin
						cen_x_q <= sat_coord(ext_coord(cen_x_q) + ext_coord(sh_x_q));
						cen_y_q <= sat_coord(ext_coord(cen_y_q) + ext_coord(sh_y_q));
						cen_z_q <= sat_coord(ext_coord(cen_z_q) + ext_coord(sh_z_q));
					end
					corner_q[cidx_q].x <= sat_coord(ext_coord(cur.x) + ext_coord(sh_x_q));
					corner_q[cidx_q].y <= sat_coord(ext_coord(cur.y) + ext_coord(sh_y_q));
					corner_q[cidx_q].z <= sat_coord(ext_coord(cur.z) + ext_coord(sh_z_q));
					cidx_q <= cidx_q + 3'd1;
					if (cidx_q == 3'd7) begin
						state_q <= S_OUT;
					end
				end

				S_PLACE: begin
					if (cidx_q == 3'd0) begin
						cen_x_q <= scx_q;
						cen_y_q <= scy_q;
						cen_z_q <= scz_q;
					end
					corner_q[cidx_q].x <= sat_coord(cidx_q[0] ? ext_coord(scx_q) - hv
						: ext_coord(scx_q) + hv);
					corner_q[cidx_q].y <= sat_coord(cidx_q[1] ? ext_coord(scy_q) - hv
						: ext_coord(scy_q) + hv);
					corner_q[cidx_q].z <= sat_coord(cidx_q[2] ? ext_coord(scz_q) - hv
						: ext_coord(scz_q) + hv);
					cidx_q <= cidx_q + 3'd1;
					if (cidx_q == 3'd7) begin
						state_q <= S_OUT;
					end
				end

				S_OUT: begin
					if (out_acc) begin
						cidx_q <= cidx_q + 3'd1;
						if (cidx_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result port: the corner under the counter while reporting.
	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = state_q == S_OUT;
	assign corner_index = cidx_q;
	assign corner_x     = cur.x;
	assign corner_y     = cur.y;
	assign corner_z     = cur.z;
	assign last_corner  = cidx_q == 3'd7;

`ifndef SYNTHESIS
	// Results and requests never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result offered while request port open");

	// The eighth result closes the run.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_corner) |=> (!out_valid && !in_stall))
		else $error("run did not close after last corner");

	// A request always starts from the first corner.
	a_first_corner: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (corner_index == 3'd0))
		else $error("results did not start at corner zero");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_cube_corner_rotate_translate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube corner core testbench
// Drives rotate, move, place and unused-code requests with random idling on both channels.
// A behavioral model of the cube predicts all eight corners of every request,
// and the monitor checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cube_corner_rotate_translate_core import ccrt_pkg::*; ;

	localparam longint SAT_HI_L = 64'sd2147483647;
	localparam longint SAT_LO_L = -64'sd2147483648;
	localparam longint OFS_LIM = (64'sd1 << 50) - 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [3:0] ADDR_CX = {REG_CENTER_X, 2'b00};
	localparam logic [3:0] ADDR_CY = {REG_CENTER_Y, 2'b00};
	localparam logic [3:0] ADDR_CZ = {REG_CENTER_Z, 2'b00};
	localparam logic [3:0] ADDR_EDGE = {REG_EDGE, 2'b00};

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] sz;
	} request_t;

	typedef struct packed {
		logic [2:0] idx;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic last;
	} corner_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [15:0] angle_x = '0;
	logic [15:0] angle_y = '0;
	logic [15:0] angle_z = '0;
	logic signed [31:0] shift_x = '0;
	logic signed [31:0] shift_y = '0;
	logic signed [31:0] shift_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] corner_index;
	logic signed [31:0] corner_x;
	logic signed [31:0] corner_y;
	logic signed [31:0] corner_z;
	logic last_corner;

	// Model state and configuration shadow.
	longint start_ctr[3];
	longint edge_len;
	longint cube_ctr[3];
	longint corners[8][3];

	request_t pending_reqs[$];
	corner_res_t expected_corners[$];
	int error_count = 0;
	bit no_idle = 1'b0;
	bit hold_sender = 1'b0;
	int idle_cycles = 0;

	cube_corner_rotate_translate_core dut (.*);

	// Clock generation.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clamp_coord(longint v);
		return v > SAT_HI_L ? SAT_HI_L : (v < SAT_LO_L ? SAT_LO_L : v);
	endfunction

	// Truncated Taylor series in unsigned Q30.
	function automatic longint unsigned series_q30(longint unsigned x, bit is_cos);
		longint unsigned x2, t;
		longint unsigned den[5];
		if (is_cos) den = '{90, 56, 30, 12, 2};
		else den = '{110, 72, 42, 20, 6};
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int i = 0; i < 5; i++)
			t = (64'd1 << 30) - ((x2 * t) >> 30) / den[i];
		return is_cos ? t : (x * t) >> 30;
	endfunction

	// Sine and cosine of a binary angle, rounded to 16 fraction bits.
	task automatic angle_trig(input logic [15:0] a, output longint s, output longint c);
		longint unsigned r, m, x, sv, cv, tmp;
		logic [1:0] quad;
		bit swap;
		longint sr, cr;
		quad = a[15:14];
		r = a[13:0];
		swap = r > 64'd8192;
		m = swap ? 64'd16384 - r : r;
		x = (m * 64'd1686629713 + 64'd8192) >> 14;
		sv = series_q30(x, 1'b0);
		cv = series_q30(x, 1'b1);
		if (swap) begin
			tmp = sv;
			sv = cv;
			cv = tmp;
		end
		sr = longint'((sv + 64'd8192) >> 14);
		cr = longint'((cv + 64'd8192) >> 14);
		case (quad)
			2'd0: begin s = sr; c = cr; end
			2'd1: begin s = cr; c = -sr; end
			2'd2: begin s = -sr; c = -cr; end
			default: begin s = -cr; c = sr; end
		endcase
	endtask

	// Product rounded half away from zero at 16 fraction bits.
	function automatic longint round_mul(longint d, longint t);
		longint unsigned md, mt, r;
		bit neg;
		if (d > OFS_LIM) d = OFS_LIM;
		if (d < -OFS_LIM) d = -OFS_LIM;
		neg = (d < 0) != (t < 0);
		md = d < 0 ? -d : d;
		mt = t < 0 ? -t : t;
		r = ((md >> 24) * mt) << 8;
		r += ((md & 64'hFFFFFF) * mt + 64'd32768) >> 16;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	task automatic plane_turn(inout longint a, inout longint b, input longint s, input longint c);
		longint na, nb;
		na = round_mul(a, c) - round_mul(b, s);
		nb = round_mul(a, s) + round_mul(b, c);
		a = na;
		b = nb;
	endtask

	task automatic place_corners();
		longint h;
		h = edge_len << 15;
		for (int j = 0; j < 3; j++) cube_ctr[j] = start_ctr[j];
		for (int k = 0; k < 8; k++)
			for (int j = 0; j < 3; j++)
				corners[k][j] = clamp_coord(cube_ctr[j] + (((k >> j) & 1) ? -h : h));
	endtask

	// Apply one request to the model and queue the eight corners it reports.
	task automatic predict_corners(input request_t rq);
		longint sx, cx, sy, cy, sz, cz, sh;
		longint d[3];
		if (rq.kind == REQ_ROTATE) begin
			angle_trig(rq.ax, sx, cx);
			angle_trig(rq.ay, sy, cy);
			angle_trig(rq.az, sz, cz);
			for (int k = 0; k < 8; k++) begin
				for (int j = 0; j < 3; j++) d[j] = corners[k][j] - cube_ctr[j];
				plane_turn(d[1], d[2], sx, cx);
				plane_turn(d[2], d[0], sy, cy);
				plane_turn(d[0], d[1], sz, cz);
				for (int j = 0; j < 3; j++) corners[k][j] = clamp_coord(cube_ctr[j] + d[j]);
			end
		end else if (rq.kind == REQ_MOVE) begin
			for (int j = 0; j < 3; j++) begin
				sh = (j == 0) ? longint'(signed'(rq.sx)) :
					(j == 1) ? longint'(signed'(rq.sy)) : longint'(signed'(rq.sz));
				cube_ctr[j] = clamp_coord(cube_ctr[j] + sh);
				for (int k = 0; k < 8; k++) corners[k][j] = clamp_coord(corners[k][j] + sh);
			end
		end else if (rq.kind == REQ_PLACE) begin
			place_corners();
		end
		for (int k = 0; k < 8; k++)
			expected_corners.push_back('{3'(k), corners[k][0][31:0], corners[k][1][31:0],
				corners[k][2][31:0], k == 7});
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Register write through the configuration port, mirrored into the model.
	task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_CX: start_ctr[0] = longint'(signed'(value));
			ADDR_CY: start_ctr[1] = longint'(signed'(value));
			ADDR_CZ: start_ctr[2] = longint'(signed'(value));
			default: edge_len = value[14:0];
		endcase
	endtask

	function automatic request_t make_req(logic [1:0] kind, logic [15:0] ax, logic [15:0] ay,
		logic [15:0] az, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		return '{kind, ax, ay, az, sx, sy, sz};
	endfunction

	function automatic logic [31:0] rand_shift();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'(signed'($urandom_range(0, 400000)) - 200000);
		endcase
	endfunction

	function automatic request_t rand_req();
		request_t rq;
		int sel;
		sel = $urandom_range(0, 99);
		rq.kind = sel < 55 ? REQ_ROTATE : (sel < 80 ? REQ_MOVE : (sel < 95 ? REQ_PLACE : 2'd3));
		rq.ax = 16'($urandom);
		rq.ay = 16'($urandom);
		rq.az = 16'($urandom);
		rq.sx = rand_shift();
		rq.sy = rand_shift();
		rq.sz = rand_shift();
		return rq;
	endfunction

	// Wait until every queued request has gone and every corner has arrived.
	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_corners.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_stall)) begin
			if (pending_reqs.size() != 0 && !hold_sender
				&& (no_idle || $urandom_range(0, 99) >= 30)) begin
				request_t rq;
				rq = pending_reqs.pop_front();
				predict_corners(rq);
				in_valid <= 1'b1;
				req_type <= rq.kind;
				angle_x <= rq.ax;
				angle_y <= rq.ay;
				angle_z <= rq.az;
				shift_x <= rq.sx;
				shift_y <= rq.sy;
				shift_z <= rq.sz;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor, receiver stalls and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_corners.size() == 0) begin
					report_mismatch($sformatf("unexpected corner %0d", corner_index));
				end else begin
					corner_res_t e;
					e = expected_corners.pop_front();
					if (corner_index !== e.idx)
						report_mismatch($sformatf("corner_index %0d, want %0d", corner_index, e.idx));
					if (corner_x !== e.x)
						report_mismatch($sformatf("corner %0d x %0d, want %0d", e.idx, corner_x, signed'(e.x)));
					if (corner_y !== e.y)
						report_mismatch($sformatf("corner %0d y %0d, want %0d", e.idx, corner_y, signed'(e.y)));
					if (corner_z !== e.z)
						report_mismatch($sformatf("corner %0d z %0d, want %0d", e.idx, corner_z, signed'(e.z)));
					if (last_corner !== e.last)
						report_mismatch($sformatf("corner %0d last_corner %0b", e.idx, last_corner));
				end
			end
			out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 30);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		for (int j = 0; j < 3; j++) start_ctr[j] = 0;
		edge_len = 50;
		place_corners();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: the reset cube, quadrant and eighth-turn angles, extreme moves.
		pending_reqs.push_back(make_req(2'd3, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h4000, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 0, 16'h8000, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 0, 0, 16'hC000, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h2000, 16'h2001, 16'h1FFF, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h5555, 16'hAAAA, 16'h0001, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_MOVE, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h1234, 16'h4321, 16'h6000, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_MOVE, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
		pending_reqs.push_back(make_req(REQ_MOVE, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
		pending_reqs.push_back(make_req(REQ_PLACE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_MOVE, 0, 0, 0, 32'h00010000, 32'hFFFF0000, 32'h5A5A5A5A));
		drain();

		// Largest edge, center at the positive x and negative y extremes.
		write_reg(ADDR_CX, 32'h7FFFFFFF);
		write_reg(ADDR_CY, 32'h80000000);
		write_reg(ADDR_CZ, 32'h00000000);
		write_reg(ADDR_EDGE, 32'h00007FFF);
		pending_reqs.push_back(make_req(REQ_PLACE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h3000, 16'h9000, 16'hE000, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_MOVE, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
		pending_reqs.push_back(make_req(REQ_PLACE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h7FFF, 16'h0000, 16'h8001, 0, 0, 0));
		drain();

		// Zero edge, then random phases with random configuration.
		write_reg(ADDR_EDGE, 32'h00000000);
		pending_reqs.push_back(make_req(REQ_PLACE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_ROTATE, 16'h1111, 16'h2222, 16'h3333, 0, 0, 0));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ADDR_CX, ph == 0 ? 32'h80000000 : $urandom);
			write_reg(ADDR_CY, ph == 0 ? 32'h7FFFFFFF : 32'(signed'($urandom_range(0, 20000000)) - 10000000));
			write_reg(ADDR_CZ, $urandom);
			write_reg(ADDR_EDGE, ph == 1 ? 32'hFFFFFFFF : $urandom_range(0, 3000));
			no_idle = (ph == 2);
			pending_reqs.push_back(make_req(REQ_PLACE, 0, 0, 0, 0, 0, 0));
			for (int i = 0; i < 34; i++) pending_reqs.push_back(rand_req());
			if (ph == 3) begin
				// The sender holds off until every corner so far has come back.
				while (pending_reqs.size() > 17) @(posedge clk);
				hold_sender = 1'b1;
				while (in_valid || expected_corners.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end
		no_idle = 1'b0;
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
